### src/cwa_pkg.sv
`default_nettype none
package cwa_pkg;
  localparam int unsigned SampleW = 20;
  localparam int unsigned AvgW = 21;
  localparam int unsigned RadiusW = 5;
  localparam int unsigned CountW = 7;
  localparam logic [CountW-1:0] CountMax = 7'd127;

  // One unit of work from the front part to the back part.
  typedef struct packed {
    logic                  do_avg;
    logic                  avg_valid;
    logic [CountW-1:0]     pad_count;
    logic                  last;
  } cwa_job_t;
endpackage
`default_nettype wire

### src/cwa_ram.sv
`default_nettype none
module cwa_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 63
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/cwa_divider.sv
`default_nettype none
module cwa_divider import cwa_pkg::*; #(
  parameter int unsigned SumW = 26,
  parameter int unsigned LenW = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SumW-1:0]   dividend_i,
  input  wire logic [LenW-1:0]   divisor_i,
  output logic                   done_o,
  output logic [SumW-1:0]        quotient_o
);
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] quo_q, quo_d;
  logic [LenW:0]   rem_q, rem_d;
  logic [LenW-1:0] div_q;
  logic [StepW-1:0] step_q, step_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [LenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[LenW-1:0], quo_q[SumW-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      step_d = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

### src/cwa_front.sv
`default_nettype none
module cwa_front import cwa_pkg::*; #(
  parameter int unsigned MaxRadius = 31,
  parameter int unsigned SumW = 26
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RadiusW-1:0]  cfg_radius_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SampleW-1:0]  sample_i,
  input  wire logic                end_of_array_i,
  output logic                     job_valid_o,
  input  wire logic                job_ready_i,
  output cwa_job_t                 job_o,
  output logic [SumW-1:0]          job_sum_o,
  output logic [CountW-1:0]        len_o
);
  localparam int unsigned Depth = 2 * MaxRadius + 1;
  localparam int unsigned PtrW = $clog2(Depth);

  // Per sample: read the outgoing sample, then update the window.
  logic [RadiusW-1:0] radius_q;
  logic [CountW-1:0]  k, count_q, count_d;
  logic [PtrW-1:0]    wp_q, wp_d, old_pos;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               phase_q, phase_d;
  logic [SampleW-1:0] s_q, old_sample;
  logic               last_q;
  logic               go;
  logic [PtrW:0]      pos_ext;

  assign k = (CountW'(radius_q) > CountW'(MaxRadius)) ? CountW'(MaxRadius) : CountW'(radius_q);
  assign len_o = CountW'((k << 1) + 1'b1);
  assign pos_ext = (PtrW+1)'(wp_q) + (PtrW+1)'(Depth) - (PtrW+1)'(len_o);
  assign old_pos = (pos_ext >= (PtrW+1)'(Depth)) ? PtrW'(pos_ext - (PtrW+1)'(Depth))
                                                 : PtrW'(pos_ext);
  assign in_ready_o = !phase_q;
  assign go = phase_q && job_ready_i;

  cwa_ram #(.Width(SampleW), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (go),
    .waddr_i (wp_q),
    .wdata_i (s_q),
    .raddr_i (old_pos),
    .rdata_o (old_sample)
  );

  always_comb begin
    sum_d = sum_q;
    count_d = count_q;
    wp_d = wp_q;
    phase_d = phase_q;
    job_valid_o = 1'b0;
    job_o = '0;
    job_sum_o = sum_q + SumW'(s_q);
    if (count_q >= len_o) begin
      job_sum_o = sum_q + SumW'(s_q) - SumW'(old_sample);
    end
    if (phase_q) begin
      job_valid_o = 1'b1;
      job_o.do_avg = count_q >= k;
      job_o.avg_valid = count_q >= (k << 1);
      job_o.last = last_q;
      job_o.pad_count = last_q ? ((count_q >= k) ? k : count_q + 1'b1) : '0;
    end
    if (in_valid_i && !phase_q) begin
      phase_d = 1'b1;
    end
    if (go) begin
      phase_d = 1'b0;
      sum_d = job_sum_o;
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      count_d = (count_q < CountMax) ? count_q + 1'b1 : count_q;
      if (last_q) begin
        sum_d = '0;
        count_d = '0;
        wp_d = '0;
      end
    end
    if (cfg_we_i) begin
      sum_d = '0;
      count_d = '0;
      wp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      sum_q <= '0;
      count_q <= '0;
      wp_q <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_radius_i;
      end
      sum_q <= sum_d;
      count_q <= count_d;
      wp_q <= wp_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !phase_q) begin
      s_q <= sample_i;
      last_q <= end_of_array_i;
    end
  end
endmodule
`default_nettype wire

### src/cwa_back.sv
`default_nettype none
module cwa_back import cwa_pkg::*; #(
  parameter int unsigned SumW = 26
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire cwa_job_t           job_i,
  input  wire logic [SumW-1:0]    job_sum_i,
  input  wire logic [CountW-1:0]  len_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [AvgW-1:0]         average_o,
  output logic                    last_result_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam logic [1:0] StPad  = 2'd3;

  logic [1:0]        state_q, state_d;
  cwa_job_t          job_q;
  logic [CountW-1:0] pad_q, pad_d;
  logic              ovalid_q, ovalid_d;
  logic [AvgW-1:0]   avg_q, avg_d;
  logic              olast_q, olast_d;
  logic              div_start, div_done;
  logic [SumW-1:0]   quotient;
  logic              take;

  assign take = job_valid_i && state_q == StIdle && !ovalid_q;
  assign job_ready_o = state_q == StIdle && !ovalid_q;
  assign div_start = take && job_i.do_avg && job_i.avg_valid;

  cwa_divider #(.SumW(SumW), .LenW(CountW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (job_sum_i),
    .divisor_i  (len_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    pad_d = pad_q;
    ovalid_d = ovalid_q;
    avg_d = avg_q;
    olast_d = olast_q;
    if (ovalid_q && pop_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (take) begin
          pad_d = job_i.pad_count;
          if (job_i.do_avg && job_i.avg_valid) begin
            state_d = StDiv;
          end else if (job_i.do_avg) begin
            state_d = StOut;
          end else begin
            state_d = StPad;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovalid_d) begin
          ovalid_d = 1'b1;
          avg_d = job_q.avg_valid ? AvgW'(quotient) : '1;
          olast_d = job_q.last && pad_q == '0;
          state_d = StPad;
        end
      end
      StPad: begin
        if (pad_q == '0) begin
          state_d = StIdle;
        end else if (!ovalid_d) begin
          ovalid_d = 1'b1;
          avg_d = '1;
          olast_d = pad_q == CountW'(1);
          pad_d = pad_q - 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovalid_q <= 1'b0;
      pad_q <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      pad_q <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
    olast_q <= olast_d;
    if (take) begin
      job_q <= job_i;
    end
  end

  assign empty_o = !ovalid_q;
  assign average_o = avg_q;
  assign last_result_o = olast_q;
endmodule
`default_nettype wire

### src/centered_window_average.sv
// A result that needs a division waits for the bit-serial divider to finish.
// The front part takes a new sample only after its last job has gone to the back part;
// the back part takes a new job only when idle and its result has been popped, and it
// emits padding results after the last sample of an array.
// Reset clears the radius, sum, count, pointer and all handshake state; the window store is
// not cleared.
`default_nettype none
module centered_window_average import cwa_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RadiusW-1:0] cfg_radius_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               end_of_array_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [AvgW-1:0]         average_o,
  output logic                    last_result_o
);
  localparam int unsigned SumW = SampleW + $clog2(2 * MAX_RADIUS + 1);

  logic              in_ready, job_valid, job_ready;
  cwa_job_t          job;
  logic [SumW-1:0]   job_sum;
  logic [CountW-1:0] len;

  assign full = !in_ready;

  cwa_front #(.MaxRadius(MAX_RADIUS), .SumW(SumW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_radius_i   (cfg_radius_i),
    .in_valid_i     (push),
    .in_ready_o     (in_ready),
    .sample_i       (sample_i),
    .end_of_array_i (end_of_array_i),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_o          (job),
    .job_sum_o      (job_sum),
    .len_o          (len)
  );

  cwa_back #(.SumW(SumW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .job_sum_i     (job_sum),
    .len_i         (len),
    .empty_o       (empty),
    .pop_i         (pop),
    .average_o     (average_o),
    .last_result_o (last_result_o)
  );
endmodule
`default_nettype wire

### src/cwa_checker.sv
`default_nettype none
module cwa_checker import cwa_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            full,
  input wire logic            push,
  input wire logic            empty,
  input wire logic            pop,
  input wire logic [AvgW-1:0] average_o,
  input wire logic            last_result_o
);
  // A waiting result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(average_o) && $stable(last_result_o))
    else $error("result changed before transfer");

  // A valid average never carries a negative value other than the incomplete marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && average_o[AvgW-1] |-> average_o == '1)
    else $error("negative average");

  // The front part is full in the cycle after each accepted sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("input accepted on consecutive cycles");
endmodule

bind centered_window_average cwa_checker u_cwa_checker (.*);
`default_nettype wire

### tb/centered_window_average_tb.sv
`timescale 1ns / 1ps
module centered_window_average_tb;
  import cwa_pkg::*;

  localparam int unsigned MaxRadius = 31;
  localparam int unsigned StoreDepth = 2 * MaxRadius + 1;
  localparam logic [AvgW-1:0] NoAverage = '1;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [AvgW-1:0] average;
    logic            last;
  } avg_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RadiusW-1:0] cfg_radius_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [SampleW-1:0] sample_i = '0;
  logic               end_of_array_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [AvgW-1:0]    average_o;
  logic               last_result_o;

  logic [RadiusW-1:0] radius_q;
  logic [SampleW-1:0] window_q [StoreDepth];
  logic [31:0]        window_sum_q;
  logic [CountW-1:0]  count_q;
  int unsigned        wr_ptr_q;
  avg_result_t        expected_q [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  int unsigned pop_hold = 0;

  always #5 clk_i = ~clk_i;

  centered_window_average #(.MAX_RADIUS(MaxRadius)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_radius_i   (cfg_radius_i),
    .push           (push),
    .full           (full),
    .sample_i       (sample_i),
    .end_of_array_i (end_of_array_i),
    .empty          (empty),
    .pop            (pop),
    .average_o      (average_o),
    .last_result_o  (last_result_o)
  );

  function automatic void restart_array();
    window_sum_q = '0;
    count_q = '0;
    wr_ptr_q = 0;
  endfunction

  function automatic void predict_averages(logic [SampleW-1:0] s, logic eoa);
    int unsigned k;
    int unsigned len;
    int unsigned idx;
    int unsigned pending;
    avg_result_t r;
    k = (radius_q > MaxRadius) ? MaxRadius : radius_q;
    len = 2 * k + 1;
    idx = count_q;
    if (idx >= len) begin
      window_sum_q -= window_q[(wr_ptr_q + StoreDepth - len) % StoreDepth];
    end
    window_sum_q += s;
    window_q[wr_ptr_q] = s;
    wr_ptr_q = (wr_ptr_q + 1) % StoreDepth;
    if (count_q != CountMax) count_q++;
    if (idx >= k) begin
      r.average = (idx >= 2 * k) ? AvgW'(window_sum_q / len) : NoAverage;
      r.last = 1'b0;
      expected_q.push_back(r);
    end
    if (eoa) begin
      pending = (idx >= k) ? k : idx + 1;
      for (int unsigned j = 0; j < pending; j++) begin
        r.average = NoAverage;
        r.last = 1'b0;
        expected_q.push_back(r);
      end
      expected_q[$].last = 1'b1;
      restart_array();
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout, %0d results outstanding", $time, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (steady) begin
      pop <= 1'b1;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 4);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    avg_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: average %h last %b", $time, average_o,
                 last_result_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (average_o !== want.average) begin
          $display("%0t average: expected %h actual %h", $time, want.average, average_o);
          error_count++;
        end
        if (last_result_o !== want.last) begin
          $display("%0t last_result: expected %b actual %b", $time, want.last,
                   last_result_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_sample(logic [SampleW-1:0] s, logic eoa);
    int unsigned gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    sample_i <= s;
    end_of_array_i <= eoa;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_averages(s, eoa);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RadiusW-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_radius_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_q = value;
    restart_array();
  endtask

  task automatic send_array(int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(SampleW'($urandom), close && (i == len - 1));
    end
  endtask

  task automatic test_passthrough();
    write_radius('0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(SampleW'(20'h5A5A5), 1'b1);
    send_sample('1, 1'b1);
  endtask

  task automatic test_short_arrays();
    write_radius(RadiusW'(3));
    send_sample('1, 1'b1);
    send_array(3, 1'b1);
    send_array(6, 1'b1);
    send_array(7, 1'b1);
  endtask

  task automatic test_restart_mid_array();
    write_radius(RadiusW'(2));
    send_array(7, 1'b0);
    write_radius(RadiusW'(1));
    send_array(5, 1'b1);
  endtask

  task automatic test_random_arrays();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 16) begin
      case ($urandom_range(0, 3))
        0: write_radius('0);
        1: write_radius('1);
        default: write_radius(RadiusW'($urandom_range(1, 6)));
      endcase
      len = $urandom_range(1, 8);
      send_array(len, 1'b1);
      sent += len;
    end
  endtask

  task automatic test_widest_window();
    write_radius('1);
    steady = 1'b1;
    for (int unsigned i = 0; i < 64; i++) send_sample('1, i == 63);
  endtask

  initial begin
    radius_q = '0;
    restart_array();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_short_arrays();
    test_restart_mid_array();
    test_random_arrays();
    test_widest_window();
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### filelist.f
src/cwa_pkg.sv
src/cwa_ram.sv
src/cwa_divider.sv
src/cwa_front.sv
src/cwa_back.sv
src/centered_window_average.sv
src/cwa_checker.sv
tb/centered_window_average_tb.sv
